// ===== src/text_terminal_cell_buffer_macros.svh =====
// Assertion macros used by the terminal cell buffer module.
`ifndef TEXT_TERMINAL_CELL_BUFFER_MACROS_SVH
`define TEXT_TERMINAL_CELL_BUFFER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTCB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ttcb assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TTCB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ttcb assertion failed");

`endif

// ===== src/ttcb_pkg.sv =====
package ttcb_pkg;

  localparam int DEF_COLS = 80;
  localparam int DEF_ROWS = 25;

  localparam int OP_W     = 3;
  localparam int CHAR_W   = 8;
  localparam int COLOUR_W = 24;
  localparam int POSC_W   = 7;
  localparam int POSR_W   = 5;

  localparam logic [CHAR_W-1:0]   BS_CODE      = 8'h08;
  localparam logic [CHAR_W-1:0]   SPACE_CODE   = 8'h20;
  localparam logic [COLOUR_W-1:0] PEN_RESET    = 24'hFFFFFF;

  typedef enum logic [OP_W-1:0] {
    OP_PUT       = 3'd0,
    OP_NEWLINE   = 3'd1,
    OP_BACKSPACE = 3'd2,
    OP_CLEAR     = 3'd3,
    OP_LEFT      = 3'd4,
    OP_RIGHT     = 3'd5,
    OP_SET       = 3'd6,
    OP_READ      = 3'd7
  } op_t;

  typedef enum logic [3:0] {
    ST_RST_CLR,
    ST_IDLE,
    ST_SCROLL,
    ST_SHIFT,
    ST_INS_LAST,
    ST_CLEAR,
    ST_READ,
    ST_READ_WAIT,
    ST_DONE
  } state_t;

endpackage

// ===== src/ttcb_cmd_if.sv =====
interface ttcb_cmd_if;
  import ttcb_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [CHAR_W-1:0]   char_code;
  logic [POSC_W-1:0]   pos_col;
  logic [POSR_W-1:0]   pos_row;

  modport source (output valid, operation, char_code, pos_col, pos_row, input ready);
  modport sink   (input valid, operation, char_code, pos_col, pos_row, output ready);
endinterface

// ===== src/ttcb_res_if.sv =====
interface ttcb_res_if;
  import ttcb_pkg::*;

  logic                valid;
  logic                ready;
  logic [CHAR_W-1:0]   cell_char;
  logic [COLOUR_W-1:0] cell_colour;
  logic [POSC_W-1:0]   cursor_col;
  logic [POSR_W-1:0]   cursor_row;

  modport source (output valid, cell_char, cell_colour, cursor_col, cursor_row, input ready);
  modport sink   (input valid, cell_char, cell_colour, cursor_col, cursor_row, output ready);
endinterface

// ===== src/text_terminal_cell_buffer.sv =====
// Channel  Direction  Contents
// cmd      in         operation, char_code, pos_col, pos_row
// res      out        cell_char, cell_colour, cursor_col, cursor_row
// cfg      in         cfg_wr_en, cfg_wr_data (pen colour)
//
// Cursor moves and set cursor go through ST_DONE; read cell goes through ST_READ, ST_READ_WAIT and ST_DONE.
// Insert and delete shift one row through the simple dual-port cell memories, one cell
// per cycle, for put char and backspace; a put char on the last cell of the last row scrolls first.
// Scrolling rotates a row offset and blanks one row; clear writes a space into all ROWS*COLS cells, keeping colours.
// After reset a pass over all ROWS*COLS cells zeroes the memories before cmd.ready rises.
// A command is taken while the previous transaction still waits on res.
`include "text_terminal_cell_buffer_macros.svh"

module text_terminal_cell_buffer #(
  parameter int COLS = ttcb_pkg::DEF_COLS,
  parameter int ROWS = ttcb_pkg::DEF_ROWS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [ttcb_pkg::COLOUR_W-1:0] cfg_wr_data,
  ttcb_cmd_if.sink                      cmd,
  ttcb_res_if.source                    res
);
  import ttcb_pkg::*;

  localparam int CW = $clog2(COLS);
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int NCELLS = ROWS * COLS;
  localparam int AW = $clog2(NCELLS);

  logic [CHAR_W-1:0]   char_mem   [NCELLS];
  logic [COLOUR_W-1:0] colour_mem [NCELLS];

  state_t state, state_next;
  logic [CW-1:0] col, col_next, row_unused;
  logic [RW-1:0] row, row_next, top, top_next;
  logic [COLOUR_W-1:0] pen;
  logic [AW-1:0] sweep, sweep_next;
  logic [CW-1:0] shift_c, shift_c_next, rd_idx, rd_idx_next, wr_idx, wr_idx_next;
  logic rd_on, rd_on_next, wr_pend, wr_pend_next, is_ins, is_ins_next;
  logic is_put, is_put_next;
  logic pend_shift, pend_shift_next;
  logic [CHAR_W-1:0] ch, ch_next, rd_char, rd_char_next;
  logic [COLOUR_W-1:0] rd_colour, rd_colour_next;
  logic [POSC_W-1:0] rd_col, rd_col_next;
  logic [POSR_W-1:0] rd_row, rd_row_next;
  logic out_valid, out_valid_next;
  logic [CHAR_W-1:0] out_char, out_char_next;
  logic [COLOUR_W-1:0] out_colour, out_colour_next;
  logic [POSC_W-1:0] out_col, out_col_next;
  logic [POSR_W-1:0] out_row, out_row_next;

  logic we_char, we_colour, re;
  logic [AW-1:0] waddr, raddr;
  logic [CHAR_W-1:0] wchar, mem_char;
  logic [COLOUR_W-1:0] wcolour, mem_colour;

  logic [RW:0] phys_sum_cur, phys_sum_rd;
  logic [RW-1:0] phys_cur, phys_rd;
  logic [AW-1:0] base_cur, base_rd, base_top;
  logic rd_in_range;
  logic [15:0] col_ext, row_ext;

  assign row_unused = '0;

  always_comb begin
    phys_sum_cur = {1'b0, row} + {1'b0, top};
    phys_cur = (32'(phys_sum_cur) >= ROWS) ? RW'(32'(phys_sum_cur) - ROWS) : phys_sum_cur[RW-1:0];
    phys_sum_rd = {1'b0, RW'(rd_row)} + {1'b0, top};
    phys_rd = (32'(phys_sum_rd) >= ROWS) ? RW'(32'(phys_sum_rd) - ROWS) : phys_sum_rd[RW-1:0];
    base_cur = AW'(32'(phys_cur) * COLS);
    base_rd = AW'(32'(phys_rd) * COLS);
    base_top = AW'(32'(top) * COLS);
    rd_in_range = (32'(rd_col) < COLS) && (32'(rd_row) < ROWS);
    col_ext = 16'(col) | 16'(row_unused);
    row_ext = 16'(row);
  end

  always_ff @(posedge clk) begin
    if (we_char) begin
      char_mem[waddr] <= wchar;
    end
    if (re) begin
      mem_char <= char_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we_colour) begin
      colour_mem[waddr] <= wcolour;
    end
    if (re) begin
      mem_colour <= colour_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RST_CLR;
      col <= '0;
      row <= '0;
      top <= '0;
      pen <= PEN_RESET;
      sweep <= '0;
      rd_on <= 1'b0;
      wr_pend <= 1'b0;
      pend_shift <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      col <= col_next;
      row <= row_next;
      top <= top_next;
      if (cfg_wr_en) begin
        pen <= cfg_wr_data;
      end
      sweep <= sweep_next;
      rd_on <= rd_on_next;
      wr_pend <= wr_pend_next;
      pend_shift <= pend_shift_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    shift_c <= shift_c_next;
    rd_idx <= rd_idx_next;
    wr_idx <= wr_idx_next;
    is_ins <= is_ins_next;
    is_put <= is_put_next;
    ch <= ch_next;
    rd_char <= rd_char_next;
    rd_colour <= rd_colour_next;
    rd_col <= rd_col_next;
    rd_row <= rd_row_next;
    out_char <= out_char_next;
    out_colour <= out_colour_next;
    out_col <= out_col_next;
    out_row <= out_row_next;
  end

  always_comb begin
    state_next = state;
    col_next = col;
    row_next = row;
    top_next = top;
    sweep_next = sweep;
    shift_c_next = shift_c;
    rd_idx_next = rd_idx;
    wr_idx_next = wr_idx;
    rd_on_next = rd_on;
    wr_pend_next = wr_pend;
    is_ins_next = is_ins;
    is_put_next = is_put;
    pend_shift_next = pend_shift;
    ch_next = ch;
    rd_char_next = rd_char;
    rd_colour_next = rd_colour;
    rd_col_next = rd_col;
    rd_row_next = rd_row;
    out_char_next = out_char;
    out_colour_next = out_colour;
    out_col_next = out_col;
    out_row_next = out_row;
    out_valid_next = out_valid && !res.ready;
    we_char = 1'b0;
    we_colour = 1'b0;
    re = 1'b0;
    waddr = '0;
    raddr = '0;
    wchar = '0;
    wcolour = '0;
    cmd.ready = (state == ST_IDLE);

    unique case (state)
      ST_RST_CLR: begin
        we_char = 1'b1;
        we_colour = 1'b1;
        waddr = sweep;
        sweep_next = AW'(sweep + 1'b1);
        if (32'(sweep) == NCELLS - 1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd.valid) begin
          ch_next = cmd.char_code;
          rd_char_next = '0;
          rd_colour_next = '0;
          rd_col_next = cmd.pos_col;
          rd_row_next = cmd.pos_row;
          unique case (op_t'(cmd.operation))
            OP_PUT: begin
              is_ins_next = (cmd.char_code != BS_CODE);
              is_put_next = 1'b1;
              rd_on_next = 1'b1;
              wr_pend_next = 1'b0;
              if (32'(col) >= COLS - 1) begin
                shift_c_next = '0;
                col_next = CW'(1);
                rd_idx_next = (cmd.char_code != BS_CODE) ? CW'(COLS - 2) : CW'(1);
                if (32'(row) + 1 >= ROWS) begin
                  row_next = RW'(ROWS - 1);
                  pend_shift_next = 1'b1;
                  rd_idx_next = '0;
                  state_next = ST_SCROLL;
                end else begin
                  row_next = RW'(row + 1'b1);
                  state_next = ST_SHIFT;
                end
              end else begin
                shift_c_next = col;
                col_next = CW'(col + 1'b1);
                rd_idx_next = (cmd.char_code != BS_CODE) ? CW'(COLS - 2) : CW'(col + 1'b1);
                state_next = ST_SHIFT;
              end
            end
            OP_NEWLINE: begin
              col_next = '0;
              if (32'(row) + 1 >= ROWS) begin
                row_next = RW'(ROWS - 1);
                pend_shift_next = 1'b0;
                rd_idx_next = '0;
                state_next = ST_SCROLL;
              end else begin
                row_next = RW'(row + 1'b1);
                state_next = ST_DONE;
              end
            end
            OP_BACKSPACE: begin
              if (col == '0) begin
                col_next = CW'(COLS - 2);
                shift_c_next = CW'(COLS - 2);
                rd_idx_next = CW'(COLS - 1);
                if (row != '0) begin
                  row_next = RW'(row - 1'b1);
                end
              end else begin
                col_next = CW'(col - 1'b1);
                shift_c_next = CW'(col - 1'b1);
                rd_idx_next = col;
              end
              is_ins_next = 1'b0;
              is_put_next = 1'b0;
              rd_on_next = 1'b1;
              wr_pend_next = 1'b0;
              state_next = ST_SHIFT;
            end
            OP_CLEAR: begin
              col_next = '0;
              row_next = '0;
              sweep_next = '0;
              state_next = ST_CLEAR;
            end
            OP_LEFT: begin
              if (col != '0) begin
                col_next = CW'(col - 1'b1);
              end
              state_next = ST_DONE;
            end
            OP_RIGHT: begin
              if (32'(col) < COLS - 1) begin
                col_next = CW'(col + 1'b1);
              end
              state_next = ST_DONE;
            end
            OP_SET: begin
              col_next = (32'(cmd.pos_col) < COLS) ? CW'(cmd.pos_col) : CW'(COLS - 1);
              row_next = (32'(cmd.pos_row) < ROWS) ? RW'(cmd.pos_row) : RW'(ROWS - 1);
              state_next = ST_DONE;
            end
            OP_READ: begin
              state_next = ST_READ;
            end
          endcase
        end
      end
      ST_SCROLL: begin
        we_char = 1'b1;
        we_colour = 1'b1;
        waddr = AW'(base_top + AW'(rd_idx));
        rd_idx_next = CW'(rd_idx + 1'b1);
        if (32'(rd_idx) == COLS - 1) begin
          top_next = (32'(top) == ROWS - 1) ? '0 : RW'(top + 1'b1);
          if (pend_shift) begin
            rd_idx_next = is_ins ? CW'(COLS - 2) : CW'(shift_c + 1'b1);
            rd_on_next = 1'b1;
            wr_pend_next = 1'b0;
            state_next = ST_SHIFT;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SHIFT: begin
        if (wr_pend) begin
          we_char = 1'b1;
          we_colour = 1'b1;
          waddr = AW'(base_cur + AW'(wr_idx));
          wchar = mem_char;
          wcolour = (is_put && !is_ins && wr_idx == shift_c) ? pen : mem_colour;
        end
        if (rd_on) begin
          re = 1'b1;
          raddr = AW'(base_cur + AW'(rd_idx));
          wr_pend_next = 1'b1;
          wr_idx_next = is_ins ? CW'(rd_idx + 1'b1) : CW'(rd_idx - 1'b1);
          if (is_ins ? (rd_idx == shift_c) : (32'(rd_idx) == COLS - 1)) begin
            rd_on_next = 1'b0;
          end else begin
            rd_idx_next = is_ins ? CW'(rd_idx - 1'b1) : CW'(rd_idx + 1'b1);
          end
        end else begin
          wr_pend_next = 1'b0;
          state_next = is_ins ? ST_INS_LAST : ST_DONE;
        end
      end
      ST_INS_LAST: begin
        we_char = 1'b1;
        we_colour = 1'b1;
        waddr = AW'(base_cur + AW'(shift_c));
        wchar = ch;
        wcolour = pen;
        state_next = ST_DONE;
      end
      ST_CLEAR: begin
        we_char = 1'b1;
        waddr = sweep;
        wchar = SPACE_CODE;
        sweep_next = AW'(sweep + 1'b1);
        if (32'(sweep) == NCELLS - 1) begin
          state_next = ST_DONE;
        end
      end
      ST_READ: begin
        re = rd_in_range;
        raddr = AW'(base_rd + AW'(rd_col));
        state_next = ST_READ_WAIT;
      end
      ST_READ_WAIT: begin
        if (rd_in_range) begin
          rd_char_next = mem_char;
          rd_colour_next = mem_colour;
        end
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || res.ready) begin
          out_valid_next = 1'b1;
          out_char_next = rd_char;
          out_colour_next = rd_colour;
          out_col_next = col_ext[POSC_W-1:0];
          out_row_next = row_ext[POSR_W-1:0];
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign res.valid = out_valid;
  assign res.cell_char = out_char;
  assign res.cell_colour = out_colour;
  assign res.cursor_col = out_col;
  assign res.cursor_row = out_row;

  `TTCB_ASSERT_SAME(a_no_same_addr, we_char && re, waddr != raddr)
  `TTCB_ASSERT_SAME(a_col_range, 1'b1, 32'(col) < COLS)
  `TTCB_ASSERT_SAME(a_row_range, 1'b1, 32'(row) < ROWS)
  `TTCB_ASSERT_NEXT(a_top_range, state == ST_SCROLL, 32'(top) < ROWS)

endmodule
